// ===== rtl/pswrl_pkg.sv =====
package pswrl_pkg;

  localparam int KEY_W   = 22;
  localparam int TIME_W  = 64;
  localparam int COUNT_W = 16;
  localparam int DROP_W  = 32;
  localparam int LIMIT_W = 16;
  localparam int WIN_W   = 40;
  localparam int CFG_W   = 40;

  localparam logic [LIMIT_W-1:0] RESET_LIMIT  = 16'd300;
  localparam logic [WIN_W-1:0]   RESET_WINDOW = 40'd1000000000;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_FLOOD   = 1'b1;

  typedef enum logic [0:0] {
    CFG_LIMIT  = 1'b0,
    CFG_WINDOW = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  start;
    logic [COUNT_W-1:0] count;
    logic [DROP_W-1:0]  drop;
  } entry_t;

  typedef struct packed {
    logic commit;
    logic sel;
  } cell_ctl_t;

endpackage

// ===== rtl/per_source_window_rate_limiter_unit.sv =====
// Per-source fixed-window rate limiter. Each item carries a source key and a
// 64-bit nanosecond timestamp; the block answers with a verdict (kind 0,
// last 1) saying whether the event is allowed, preceded by a flood report
// (kind 1, allowed 1, last 0) carrying the dropped total of the source's
// previous window when that total was nonzero and the event is allowed.
// Sources live in a row of TABLE_ENTRIES cells, one per source, replaced
// least recently used first once no free cell is left. Each item passes the
// key match across the cell row and slot choice (ST_LOOKUP), then the window
// arithmetic and write-back into the chosen cell (ST_UPDATE). The next item is
// taken in the write-back cycle, while the last item is being written back;
// the write-back waits while the result buffer (one result plus a pending
// verdict) cannot take the new results. No clearing pass after reset. The user
// writes configuration (index 0 events_per_window, index 1 window_length)
// only while the block is idle; the block itself does not enforce this.
module per_source_window_rate_limiter_unit #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pswrl_pkg::KEY_W-1:0]   source_key,
  input  logic [pswrl_pkg::TIME_W-1:0]  timestamp,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [pswrl_pkg::CFG_W-1:0]   cfg_data,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic                          allowed,
  output logic [pswrl_pkg::DROP_W-1:0]  dropped_count,
  output logic                          last
);

  localparam int RANK_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int LRU    = TABLE_ENTRIES - 1;

  pswrl_pkg::state_t state, state_next;

  logic [pswrl_pkg::LIMIT_W-1:0] limit;
  logic [pswrl_pkg::WIN_W-1:0]   wlen;

  logic [pswrl_pkg::KEY_W-1:0]   key_q;
  logic [pswrl_pkg::TIME_W-1:0]  now_q;

  logic                          in_take;
  logic                          out_take;
  logic                          out_room;
  logic                          commit;
  logic                          pend_valid;

  // cell row
  logic [TABLE_ENTRIES:0]        free_chain;
  logic [TABLE_ENTRIES-1:0]      hit_v;
  logic [TABLE_ENTRIES-1:0]      ffree_v;
  logic [TABLE_ENTRIES-1:0]      lru_v;
  logic [TABLE_ENTRIES-1:0]      sel_v;
  logic [TABLE_ENTRIES-1:0]      sel_q;
  pswrl_pkg::entry_t             ent_v  [TABLE_ENTRIES];
  logic [RANK_W-1:0]             rank_v [TABLE_ENTRIES];

  logic                          any_hit;
  pswrl_pkg::entry_t             ent_mux;
  pswrl_pkg::entry_t             ent_look;
  pswrl_pkg::entry_t             ent_q;
  logic [RANK_W-1:0]             rank_mux;
  logic [RANK_W-1:0]             rank_q;

  // window arithmetic
  logic [pswrl_pkg::TIME_W-1:0]  age;
  logic                          elapsed;
  logic [pswrl_pkg::DROP_W-1:0]  taken;
  logic [pswrl_pkg::COUNT_W-1:0] count0;
  logic [pswrl_pkg::DROP_W-1:0]  drop0;
  logic                          allow;
  logic                          flood;
  pswrl_pkg::entry_t             wr_entry;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= pswrl_pkg::RESET_LIMIT;
      wlen  <= pswrl_pkg::RESET_WINDOW;
    end else if (cfg_we) begin
      case (pswrl_pkg::cfg_index_t'(cfg_index))
        pswrl_pkg::CFG_LIMIT:  limit <= cfg_data[pswrl_pkg::LIMIT_W-1:0];
        pswrl_pkg::CFG_WINDOW: wlen  <= cfg_data[pswrl_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  assign out_take = out_valid && !out_stall;
  // the buffer can take new results when it is empty or empties this cycle
  assign out_room = !out_valid || (out_take && !pend_valid);
  assign commit   = (state == pswrl_pkg::ST_UPDATE) && out_room;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pswrl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      pswrl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = pswrl_pkg::ST_LOOKUP;
        end
      end
      pswrl_pkg::ST_LOOKUP: begin
        state_next = pswrl_pkg::ST_UPDATE;
      end
      pswrl_pkg::ST_UPDATE: begin
        // take the next item in the write-back cycle
        in_stall = !out_room;
        if (out_room) begin
          state_next = in_valid ? pswrl_pkg::ST_LOOKUP : pswrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pswrl_pkg::ST_IDLE;
      end
    endcase
  end

  // hold the item for lookup and write-back
  always_ff @(posedge clk) begin
    if (in_take) begin
      key_q <= source_key;
      now_q <= timestamp;
    end
  end

  // ---------------------------------------------------------------- cell row
  assign free_chain[0] = 1'b0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    pswrl_pkg::cell_ctl_t ctl;
    assign ctl.commit = commit;
    assign ctl.sel    = sel_q[i];

    pswrl_cell #(
      .IDX    (i),
      .RANK_W (RANK_W),
      .LRU    (LRU)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .key_in     (key_q),
      .free_in    (free_chain[i]),
      .free_out   (free_chain[i+1]),
      .hit        (hit_v[i]),
      .first_free (ffree_v[i]),
      .lru        (lru_v[i]),
      .entry      (ent_v[i]),
      .rank       (rank_v[i]),
      .ctl        (ctl),
      .wr_entry   (wr_entry),
      .rank_ref   (rank_q)
    );
  end

  // Pick the slot: the hit, else the lowest free cell, else the cell ranked
  // least recent. Ranks stay a permutation, so exactly one cell is picked.
  assign any_hit = |hit_v;

  always_comb begin
    ent_mux  = '0;
    rank_mux = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      sel_v[i] = any_hit ? hit_v[i] : (free_chain[TABLE_ENTRIES] ? ffree_v[i] : lru_v[i]);
      if (sel_v[i]) begin
        ent_mux  = ent_v[i];
        rank_mux = rank_v[i];
      end
    end
  end

  // a miss starts a fresh entry at the event's time
  always_comb begin
    if (any_hit) begin
      ent_look = ent_mux;
    end else begin
      ent_look.key   = key_q;
      ent_look.start = now_q;
      ent_look.count = '0;
      ent_look.drop  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_q <= '0;
    end else if (state == pswrl_pkg::ST_LOOKUP) begin
      sel_q <= sel_v;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pswrl_pkg::ST_LOOKUP) begin
      ent_q  <= ent_look;
      rank_q <= rank_mux;
    end
  end

  // ---------------------------------------------------------------- window
  assign age     = now_q - ent_q.start;
  assign elapsed = age >= {{(pswrl_pkg::TIME_W - pswrl_pkg::WIN_W){1'b0}}, wlen};
  assign taken   = elapsed ? ent_q.drop : '0;
  assign count0  = elapsed ? '0 : ent_q.count;
  assign drop0   = elapsed ? '0 : ent_q.drop;
  assign allow   = count0 < limit;
  assign flood   = allow && (taken != '0);

  always_comb begin
    wr_entry.key   = key_q;
    wr_entry.start = elapsed ? now_q : ent_q.start;
    wr_entry.count = (&count0) ? count0 : count0 + 1'b1;
    wr_entry.drop  = (!allow && !(&drop0)) ? drop0 + 1'b1 : drop0;
  end

  // ---------------------------------------------------------------- results
  // Head register plus one pending verdict behind a flood report; the
  // pending verdict is always an allowed one.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (commit) begin
      out_valid  <= 1'b1;
      pend_valid <= flood;
    end else if (out_take) begin
      out_valid  <= pend_valid;
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (flood) begin
        kind          <= pswrl_pkg::KIND_FLOOD;
        allowed       <= 1'b1;
        dropped_count <= taken;
        last          <= 1'b0;
      end else begin
        kind          <= pswrl_pkg::KIND_VERDICT;
        allowed       <= allow;
        dropped_count <= '0;
        last          <= 1'b1;
      end
    end else if (out_take && pend_valid) begin
      kind          <= pswrl_pkg::KIND_VERDICT;
      allowed       <= 1'b1;
      dropped_count <= '0;
      last          <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checks
  a_one_slot: assert property (@(posedge clk) disable iff (rst)
    (state == pswrl_pkg::ST_LOOKUP) |-> $onehot(sel_v))
    else $error("slot choice is not a single cell");

  a_pend_behind_flood: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (out_valid && kind == pswrl_pkg::KIND_FLOOD))
    else $error("pending verdict without a flood report at the head");

  a_flood_has_verdict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> pend_valid)
    else $error("flood report without a verdict behind it");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("write-back produced no result");

endmodule

// ===== rtl/pswrl_cell.sv =====
module pswrl_cell #(
  parameter int IDX    = 0,
  parameter int RANK_W = 5,
  parameter int LRU    = 31
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pswrl_pkg::KEY_W-1:0]  key_in,
  input  logic                         free_in,
  output logic                         free_out,
  output logic                         hit,
  output logic                         first_free,
  output logic                         lru,
  output pswrl_pkg::entry_t            entry,
  output logic [RANK_W-1:0]            rank,
  input  pswrl_pkg::cell_ctl_t         ctl,
  input  pswrl_pkg::entry_t            wr_entry,
  input  logic [RANK_W-1:0]            rank_ref
);

  logic valid;

  // match and free-slot chain
  assign hit        = valid && (entry.key == key_in);
  assign first_free = !valid && !free_in;
  assign free_out   = free_in || !valid;
  assign lru        = (rank == RANK_W'(LRU));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= RANK_W'(IDX);
    end else if (ctl.commit) begin
      if (ctl.sel) begin
        valid <= 1'b1;
        rank  <= '0;
      end else if (rank < rank_ref) begin
        rank <= rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && ctl.sel) begin
      entry <= wr_entry;
    end
  end

endmodule
